[design/srgbgray_pkg.sv]
`timescale 1ns / 1ps

package srgbgray_pkg;

    // Default number of fraction bits of a linear-light level.
    localparam int unsigned LINEAR_FRAC_BITS_DEF = 20;

    // Width of one channel code and of the gray result.
    localparam int unsigned CODE_W = 8;
    localparam int unsigned NUM_CODES = 256;

    // Luminance weights in units of 1/10000; they sum to exactly LUMA_SCALE.
    localparam int unsigned WEIGHT_RED   = 2126;
    localparam int unsigned WEIGHT_GREEN = 7152;
    localparam int unsigned WEIGHT_BLUE  = 722;
    localparam int unsigned LUMA_SCALE   = 10000;
    localparam int unsigned ROUND_BIAS   = 5000;

    // Bits that hold the largest weight, and the full luminance scale.
    localparam int unsigned WEIGHT_W = 13;
    localparam int unsigned SCALE_W  = 14;

    // Product of two Q32 numbers, truncated back to Q32.
    function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 32;
    endfunction

    // Fifth power of a Q32 number, truncated after every product.
    function automatic logic [63:0] pow5_q32(input logic [63:0] r);
        logic [63:0] r2;
        logic [63:0] r4;
        r2 = mul_q32(r, r);
        r4 = mul_q32(r2, r2);
        return mul_q32(r4, r);
    endfunction

    // sRGB code to linear light in Q32. The power 2.4 is taken as the square
    // times the fifth root, the root found bit by bit from the top.
    function automatic logic [63:0] decode_q32(input int unsigned v);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] r;
        logic [63:0] c;
        logic [63:0] res;
        if (v == 0) begin
            res = 64'd0;
        end else if (v >= 255) begin
            res = 64'd1 << 32;
        end else if (v <= 10) begin
            res = (((64'(v) * 64'd1000) << 32) + 64'd1647300) / 64'd3294600;
        end else begin
            x = ((64'(v) * 64'd1000 + 64'd14025) << 32) / 64'd269025;
            y = mul_q32(x, x);
            r = 64'd0;
            for (int b = 31; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (pow5_q32(c) <= y) begin
                    r = c;
                end
            end
            res = mul_q32(y, r);
        end
        return res;
    endfunction

    // Linear level of a code with frac fraction bits, rounded half up.
    function automatic logic [63:0] level_fixed(input int unsigned v, input int unsigned frac);
        logic [63:0] l32;
        l32 = decode_q32(v);
        return (((l32 << 1) >> (32 - frac)) + 64'd1) >> 1;
    endfunction

endpackage

[design/srgbgray_luma.sv]
`timescale 1ns / 1ps

// Three-stage luminance path: table lookup, weighting, rounded sum.
// The sum is kept at 10000 times the level scale so that no divide is needed.
module srgbgray_luma #(
    parameter int unsigned FRAC = srgbgray_pkg::LINEAR_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [srgbgray_pkg::CODE_W-1:0] i_red,
    input  logic [srgbgray_pkg::CODE_W-1:0] i_green,
    input  logic [srgbgray_pkg::CODE_W-1:0] i_blue,
    output logic                           o_ready,
    input  logic                           i_ready,
    output logic                           o_valid,
    output logic [FRAC+srgbgray_pkg::SCALE_W-1:0] o_sum
);

    localparam int unsigned LW = FRAC + 1;
    localparam int unsigned SW = FRAC + srgbgray_pkg::SCALE_W;

    // Constant table of linear levels, one entry per code.
    logic [LW-1:0] w_level [srgbgray_pkg::NUM_CODES];

    for (genvar k = 0; k < srgbgray_pkg::NUM_CODES; k++) begin : g_level
        localparam logic [LW-1:0] LV = LW'(srgbgray_pkg::level_fixed(k, FRAC));
        assign w_level[k] = LV;
    end

    logic          r_v1;
    logic          r_v2;
    logic          r_v3;
    logic [LW-1:0] r_lin_r;
    logic [LW-1:0] r_lin_g;
    logic [LW-1:0] r_lin_b;
    logic [SW-1:0] r_prod_r;
    logic [SW-1:0] r_prod_g;
    logic [SW-1:0] r_prod_b;
    logic [SW-1:0] r_sum;

    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;

    // A stage takes a new item when it is empty or its item moves on.
    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v3;
    assign o_sum   = r_sum;

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Payload: lookup, then weighted products, then sum with rounding bias.
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_lin_r <= w_level[i_red];
            r_lin_g <= w_level[i_green];
            r_lin_b <= w_level[i_blue];
        end
        if (w_rdy2 && r_v1) begin
            r_prod_r <= SW'(r_lin_r) * SW'(srgbgray_pkg::WEIGHT_RED);
            r_prod_g <= SW'(r_lin_g) * SW'(srgbgray_pkg::WEIGHT_GREEN);
            r_prod_b <= SW'(r_lin_b) * SW'(srgbgray_pkg::WEIGHT_BLUE);
        end
        if (w_rdy3 && r_v2) begin
            r_sum <= r_prod_r + r_prod_g + r_prod_b + SW'(srgbgray_pkg::ROUND_BIAS);
        end
    end

endmodule

[design/srgbgray_enc.sv]
`timescale 1ns / 1ps

// Re-encoding by a pipelined binary search: each stage settles one bit of the
// gray code by comparing the scaled luminance against a constant threshold.
// Since the levels never decrease, the largest code whose threshold fits is
// the highest of the codes at or below the luminance.
module srgbgray_enc #(
    parameter int unsigned FRAC = srgbgray_pkg::LINEAR_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [FRAC+srgbgray_pkg::SCALE_W-1:0] i_sum,
    output logic                                  o_ready,
    input  logic                                  i_ready,
    output logic                                  o_valid,
    output logic [srgbgray_pkg::CODE_W-1:0]       o_gray
);

    localparam int unsigned SW = FRAC + srgbgray_pkg::SCALE_W;
    localparam int unsigned GW = srgbgray_pkg::CODE_W;

    // Constant thresholds: each level times the luminance scale.
    logic [SW-1:0] w_thr [srgbgray_pkg::NUM_CODES];

    for (genvar k = 0; k < srgbgray_pkg::NUM_CODES; k++) begin : g_thr
        localparam logic [SW-1:0] TV =
            SW'(srgbgray_pkg::level_fixed(k, FRAC) * 64'(srgbgray_pkg::LUMA_SCALE));
        assign w_thr[k] = TV;
    end

    logic [GW-1:0] r_v;
    logic [GW-1:0] r_acc [GW];
    logic [SW-1:0] r_sum [GW];

    logic [GW:0]   w_rdy;
    logic [GW-1:0] w_v_in;
    logic [GW-1:0] w_acc_in [GW];
    logic [SW-1:0] w_sum_in [GW];
    logic [GW-1:0] w_cand [GW];
    logic [GW-1:0] w_next [GW];

    assign w_rdy[GW] = i_ready;

    for (genvar s = 0; s < GW; s++) begin : g_stage
        localparam logic [GW-1:0] STEP = GW'(1 << (GW - 1 - s));

        // Stage inputs come from the port or from the stage before.
        if (s == 0) begin : g_first
            assign w_v_in[s]   = i_valid;
            assign w_acc_in[s] = '0;
            assign w_sum_in[s] = i_sum;
        end else begin : g_rest
            assign w_v_in[s]   = r_v[s-1];
            assign w_acc_in[s] = r_acc[s-1];
            assign w_sum_in[s] = r_sum[s-1];
        end

        // Try the next lower bit set and keep it if its threshold fits.
        assign w_cand[s] = w_acc_in[s] | STEP;
        assign w_next[s] = (w_thr[w_cand[s]] <= w_sum_in[s]) ? w_cand[s] : w_acc_in[s];
        assign w_rdy[s]  = !r_v[s] || w_rdy[s+1];
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[GW-1];
    assign o_gray  = r_acc[GW-1];

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 0; s < GW; s++) begin
                if (w_rdy[s]) begin
                    r_v[s] <= w_v_in[s];
                end
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < GW; s++) begin
            if (w_rdy[s] && w_v_in[s]) begin
                r_acc[s] <= w_next[s];
                r_sum[s] <= w_sum_in[s];
            end
        end
    end

endmodule

[design/srgb_pixel_to_gray_top.sv]
`timescale 1ns / 1ps

// sRGB pixel to gray converter.
// Input channel: i_valid with i_red, i_green, i_blue; the block holds o_stall
// high when it cannot take an item. An item is taken at a clock edge where
// i_valid is high and o_stall is low.
// Output channel: o_valid with o_gray; the receiver holds i_stall high to
// keep the result in place. A result is taken where o_valid is high and
// i_stall is low.
// Path: an item taken passes through an input register, three luminance
// stages (lookup, weighting, sum), eight search stages that settle one gray
// bit each, and the output register, which drives o_gray.
// Throughput: one item per cycle while i_stall is low; every stage is a
// register with its own valid flag, so items can follow each other without gaps.
// Stall: a stalled output holds; stages behind it keep filling empty slots
// and o_stall rises once every stage up to the input register is occupied.
// Reset (i_rst_n low, synchronous) empties every stage; no result is pending
// afterwards.
module srgb_pixel_to_gray_top #(
    parameter int unsigned LINEAR_FRAC_BITS = srgbgray_pkg::LINEAR_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [srgbgray_pkg::CODE_W-1:0] i_red,
    input  logic [srgbgray_pkg::CODE_W-1:0] i_green,
    input  logic [srgbgray_pkg::CODE_W-1:0] i_blue,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [srgbgray_pkg::CODE_W-1:0] o_gray
);

    localparam int unsigned SW = LINEAR_FRAC_BITS + srgbgray_pkg::SCALE_W;
    localparam int unsigned GW = srgbgray_pkg::CODE_W;

    logic          r_in_v;
    logic [GW-1:0] r_red;
    logic [GW-1:0] r_green;
    logic [GW-1:0] r_blue;
    logic          r_out_v;
    logic [GW-1:0] r_gray;

    logic          w_in_rdy;
    logic          w_out_rdy;
    logic          w_luma_rdy;
    logic          w_luma_v;
    logic [SW-1:0] w_luma_sum;
    logic          w_enc_rdy;
    logic          w_enc_v;
    logic [GW-1:0] w_enc_gray;

    // Ready chain from the output register back to the input register.
    assign w_out_rdy = !r_out_v || !i_stall;
    assign w_in_rdy  = !r_in_v || w_luma_rdy;
    assign o_stall   = !w_in_rdy;
    assign o_valid   = r_out_v;
    assign o_gray    = r_gray;

    // Input register valid and output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_in_rdy) begin
                r_in_v <= i_valid;
            end
            if (w_out_rdy) begin
                r_out_v <= w_enc_v;
            end
        end
    end

    // Input and output payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_rdy && i_valid) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
        if (w_out_rdy && w_enc_v) begin
            r_gray <= w_enc_gray;
        end
    end

    srgbgray_luma #(
        .FRAC(LINEAR_FRAC_BITS)
    ) u_luma (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(r_in_v),
        .i_red  (r_red),
        .i_green(r_green),
        .i_blue (r_blue),
        .o_ready(w_luma_rdy),
        .i_ready(w_enc_rdy),
        .o_valid(w_luma_v),
        .o_sum  (w_luma_sum)
    );

    srgbgray_enc #(
        .FRAC(LINEAR_FRAC_BITS)
    ) u_enc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_luma_v),
        .i_sum  (w_luma_sum),
        .o_ready(w_enc_rdy),
        .i_ready(w_out_rdy),
        .o_valid(w_enc_v),
        .o_gray (w_enc_gray)
    );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

// Checks the sRGB pixel to gray converter against a predictor that builds its
// own table of linear-light levels. Random idling and backpressure are
// applied on both channels.

// Keeps the expected gray level of every accepted pixel and compares results
// in order.
class gray_checker;

    typedef struct {
        logic [srgbgray_pkg::CODE_W-1:0] red;
        logic [srgbgray_pkg::CODE_W-1:0] green;
        logic [srgbgray_pkg::CODE_W-1:0] blue;
        logic [srgbgray_pkg::CODE_W-1:0] gray;
    } t_pixel_gray;

    // Luminance weights in units of 1/10000.
    localparam logic [63:0] LUMA_R   = 64'd2126;
    localparam logic [63:0] LUMA_G   = 64'd7152;
    localparam logic [63:0] LUMA_B   = 64'd722;
    localparam logic [63:0] LUMA_DIV = 64'd10000;
    localparam logic [63:0] LUMA_RND = 64'd5000;

    logic [63:0]   lin_level [256];
    t_pixel_gray   expected_gray [$];
    int unsigned   frac_bits;
    int unsigned   n_pixels;
    int unsigned   n_grays;
    int unsigned   n_errors;

    function new(input int unsigned frac);
        logic [63:0] q32;
        frac_bits = frac;
        n_pixels  = 0;
        n_grays   = 0;
        n_errors  = 0;
        for (int code = 0; code < 256; code++) begin
            q32 = srgb_to_linear_q32(code);
            lin_level[code] = (((q32 << 1) >> (32 - frac_bits)) + 64'd1) >> 1;
        end
    endfunction

    // Q32 product with the low half dropped.
    function logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] prod;
        prod = a * b;
        return prod >> 32;
    endfunction

    // Linear light of one code in Q32. Above the linear segment the power
    // 2.4 is the square of the base times its fifth root.
    function logic [63:0] srgb_to_linear_q32(input int unsigned code);
        logic [63:0] base;
        logic [63:0] sq;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] p2;
        logic [63:0] p4;
        logic [63:0] p5;
        if (code == 0) begin
            return 64'd0;
        end
        if (code >= 255) begin
            return 64'd1 << 32;
        end
        if (code <= 10) begin
            return (((64'(code) * 64'd1000) << 32) + 64'd1647300) / 64'd3294600;
        end
        base = ((64'(code) * 64'd1000 + 64'd14025) << 32) / 64'd269025;
        sq   = qmul(base, base);
        root = 64'd0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            p2    = qmul(trial, trial);
            p4    = qmul(p2, p2);
            p5    = qmul(p4, trial);
            if (p5 <= sq) begin
                root = trial;
            end
        end
        return qmul(sq, root);
    endfunction

    // Weighted luminance, then the highest code whose level it reaches.
    function logic [7:0] predict_gray(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
        logic [63:0] weighted;
        logic [63:0] luma;
        int unsigned count;
        weighted = LUMA_R * lin_level[r] + LUMA_G * lin_level[g] + LUMA_B * lin_level[b];
        luma     = (weighted + LUMA_RND) / LUMA_DIV;
        count    = 0;
        for (int k = 1; k < 256; k++) begin
            if (lin_level[k] <= luma) begin
                count = k;
            end else begin
                break;
            end
        end
        return count[7:0];
    endfunction

    function void note_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_pixel_gray p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        p.gray  = predict_gray(r, g, b);
        expected_gray.push_back(p);
        n_pixels++;
    endfunction

    function void check_gray(input logic [7:0] got);
        t_pixel_gray p;
        if (expected_gray.size() == 0) begin
            $display("%0t: unexpected gray result: expected none, actual %0d", $time, got);
            n_errors++;
            return;
        end
        p = expected_gray.pop_front();
        n_grays++;
        if (got !== p.gray) begin
            $display("%0t: gray mismatch for pixel (%0d,%0d,%0d): expected %0d, actual %0d",
                     $time, p.red, p.green, p.blue, p.gray, got);
            n_errors++;
        end
    endfunction

    function int unsigned pending();
        return expected_gray.size();
    endfunction

endclass

module tb;

    localparam int unsigned LIN_FRAC   = srgbgray_pkg::LINEAR_FRAC_BITS_DEF;
    localparam int unsigned N_RANDOM   = 500;
    localparam int unsigned SETTLE_CYC = 24;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_red;
    logic [7:0] i_green;
    logic [7:0] i_blue;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_gray;

    gray_checker sb;
    bit          quiet;
    int unsigned n_directed;
    int unsigned hold_left;

    srgb_pixel_to_gray_top #(
        .LINEAR_FRAC_BITS(LIN_FRAC)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_gray  (o_gray)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Timeout guard.
    initial begin
        #4_000_000;
        $display("Timeout: the run did not finish in time.");
        $display("CHECKS FAILED");
        $finish;
    end

    // Record accepted pixels and check accepted gray levels.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_pixel(i_red, i_green, i_blue);
            end
            if (o_valid && !i_stall) begin
                sb.check_gray(o_gray);
            end
        end
    end

    // Receiver backpressure: short single stalls plus occasional longer holds
    // that back the pipeline up to the input.
    initial begin
        i_stall   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                i_stall <= 1'b0;
            end else if (hold_left != 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if ($urandom_range(99) < 2) begin
                i_stall   <= 1'b1;
                hold_left = $urandom_range(13, 3);
            end else begin
                i_stall <= ($urandom_range(99) < 4);
            end
        end
    end

    task automatic send_idle(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            i_red   <= 8'($urandom);
            i_green <= 8'($urandom);
            i_blue  <= 8'($urandom);
        end
    endtask

    // Present one pixel and hold it until the block takes it.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic sender_gaps();
        while (!quiet && $urandom_range(99) < 18) begin
            send_idle(1);
        end
    endtask

    // Stop sending and wait until every expected gray level has come back.
    task automatic drain_results();
        send_idle(1);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_directed(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        sender_gaps();
        send_pixel(r, g, b);
        n_directed++;
    endtask

    // Random pixel drawn from a mix of uniform, neutral, dark, bright and
    // single-channel colors.
    task automatic send_random_pixel();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] v;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        case ($urandom_range(9))
            6: begin
                v = 8'($urandom);
                r = v;
                g = v;
                b = v;
            end
            7: begin
                r = 8'($urandom_range(12));
                g = 8'($urandom_range(12));
                b = 8'($urandom_range(12));
            end
            8: begin
                r = 8'($urandom_range(255, 240));
                g = 8'($urandom_range(255, 240));
                b = 8'($urandom_range(255, 240));
            end
            9: begin
                v = 8'($urandom);
                r = 8'd0;
                g = 8'd0;
                b = 8'd0;
                case ($urandom_range(2))
                    0: r = v;
                    1: g = v;
                    default: b = v;
                endcase
            end
            default: begin
            end
        endcase
        sender_gaps();
        send_pixel(r, g, b);
    endtask

    // Stimulus.
    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_red      = 8'd0;
        i_green    = 8'd0;
        i_blue     = 8'd0;
        quiet      = 1'b0;
        n_directed = 0;
        sb         = new(LIN_FRAC);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Black, white, primaries, secondaries, edges of the linear segment, and other grays and mixes.
        send_directed(8'd0,   8'd0,   8'd0);
        send_directed(8'd255, 8'd255, 8'd255);
        send_directed(8'd255, 8'd0,   8'd0);
        send_directed(8'd0,   8'd255, 8'd0);
        send_directed(8'd0,   8'd0,   8'd255);
        send_directed(8'd1,   8'd1,   8'd1);
        send_directed(8'd10,  8'd10,  8'd10);
        send_directed(8'd11,  8'd11,  8'd11);
        send_directed(8'd10,  8'd11,  8'd10);
        send_directed(8'd254, 8'd254, 8'd254);
        send_directed(8'd128, 8'd128, 8'd128);
        send_directed(8'haa,  8'h55,  8'haa);
        send_directed(8'h55,  8'haa,  8'h55);
        send_directed(8'd255, 8'd255, 8'd0);
        send_directed(8'd0,   8'd255, 8'd255);
        send_directed(8'd255, 8'd0,   8'd255);
        send_directed(8'd254, 8'd255, 8'd254);
        drain_results();

        // Random pixels, with a stretch of no idling on either side and one
        // full drain part way through.
        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = (n >= 150 && n < 300);
            if (n == 350) begin
                drain_results();
            end
            send_random_pixel();
        end
        quiet = 1'b0;

        drain_results();
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Sent %0d pixels (%0d directed: black, white, primaries, linear-segment edges;",
                 sb.n_pixels, n_directed);
        $display("rest random mixes) under random stalls; %0d gray levels checked, %0d errors.",
                 sb.n_grays, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
